// ----- hw/rtl/prescaled_timer_with_reload_macros.svh -----
// ---------------------------------------------------------------------------
// prescaled timer assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet during reset
// ---------------------------------------------------------------------------
`ifndef PRESCALED_TIMER_WITH_RELOAD_MACROS_SVH
`define PRESCALED_TIMER_WITH_RELOAD_MACROS_SVH

// same-cycle implication
`define PTWR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PTWR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ptwr_pkg.sv -----
// ---------------------------------------------------------------------------
// ptwr_pkg
// beat types, function codes, register addresses and rate helper for the
// prescaled timer with reload
// ---------------------------------------------------------------------------
package ptwr_pkg;

  // function codes of an input beat
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // register map
  localparam logic [15:0] ADDR_DIV  = 16'hff04;
  localparam logic [15:0] ADDR_CNT  = 16'hff05;
  localparam logic [15:0] ADDR_MOD  = 16'hff06;
  localparam logic [15:0] ADDR_CTRL = 16'hff07;

  // control register layout and reset
  localparam logic [7:0] CTRL_RESET  = 8'hf8;
  localparam int unsigned CTRL_EN_BIT = 2;

  // rate select codes in control bits 1:0
  localparam logic [1:0] RATE_SEL_256   = 2'd0;
  localparam logic [1:0] RATE_SEL_16384 = 2'd1;
  localparam logic [1:0] RATE_SEL_4096  = 2'd2;
  localparam logic [1:0] RATE_SEL_1024  = 2'd3;

  // fraction widths and steps
  localparam int unsigned DIV_FRAC_W = 9;
  localparam int unsigned CNT_FRAC_W = 23;
  localparam int unsigned CNT_ADD_W  = 22;
  localparam logic [DIV_FRAC_W:0] DIV_STEP = 10'd256;
  localparam logic [CNT_FRAC_W:0] CNT_STEP = 24'd262144;
  localparam logic [CNT_FRAC_W-1:0] CNT_FRAC_MAX = 23'h7fffff;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] addr;
    logic [7:0]  write_data;
    logic [7:0]  cycles;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq;
  } out_item_t;

  // every rate is a power of two: give its log2
  function automatic logic [3:0] rate_shift(input logic [1:0] sel);
    logic [3:0] sh;
    case (sel)
      RATE_SEL_256:   sh = 4'd8;
      RATE_SEL_16384: sh = 4'd14;
      RATE_SEL_4096:  sh = 4'd12;
      RATE_SEL_1024:  sh = 4'd10;
      default:        sh = 4'd8;
    endcase
    return sh;
  endfunction

endpackage

// ----- hw/rtl/ptwr_core.sv -----
// ---------------------------------------------------------------------------
// ptwr_core
// timer state registers and the single-pass update for one beat: divider and
// counter accumulation, reload, bus decode
// ---------------------------------------------------------------------------
module ptwr_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  ptwr_pkg::in_item_t  item_i,
  output ptwr_pkg::out_item_t result_o
);
  import ptwr_pkg::*;

  logic [DIV_FRAC_W-1:0] div_frac_q, div_frac_d;
  logic [7:0]            div_q, div_d;
  logic [CNT_FRAC_W-1:0] cnt_frac_q, cnt_frac_d;
  logic [7:0]            cnt_q, cnt_d;
  logic [7:0]            mod_q, mod_d;
  logic [7:0]            ctrl_q, ctrl_d;

  logic [DIV_FRAC_W:0]   div_sum, div_rem;
  logic                  div_carry;
  logic [CNT_ADD_W-1:0]  cnt_add;
  logic [CNT_FRAC_W:0]   cnt_sum, cnt_rem;
  logic                  cnt_carry;
  logic [7:0]            cnt_inc;
  logic                  cnt_wrap;
  logic [7:0]            rd_data;

  // divider fraction path
  assign div_sum   = {1'b0, div_frac_q} + {2'b00, item_i.cycles};
  assign div_carry = (div_sum >= DIV_STEP);
  assign div_rem   = div_carry ? (div_sum - DIV_STEP) : div_sum;

  // counter fraction path, rate times cycles as a shift
  assign cnt_add   = CNT_ADD_W'(item_i.cycles) << rate_shift(ctrl_q[1:0]);
  assign cnt_sum   = {1'b0, cnt_frac_q} + {2'b00, cnt_add};
  assign cnt_carry = (cnt_sum >= CNT_STEP);
  assign cnt_rem   = cnt_carry ? (cnt_sum - CNT_STEP) : cnt_sum;
  assign cnt_inc   = cnt_q + 8'd1;
  assign cnt_wrap  = cnt_carry && (cnt_inc == 8'd0);

  // bus read decode
  always_comb begin
    unique case (item_i.addr)
      ADDR_DIV:  rd_data = div_q;
      ADDR_CNT:  rd_data = cnt_q;
      ADDR_MOD:  rd_data = mod_q;
      ADDR_CTRL: rd_data = ctrl_q;
      default:   rd_data = 8'd0;
    endcase
  end

  // next state and result for the beat
  always_comb begin
    div_frac_d = div_frac_q;
    div_d      = div_q;
    cnt_frac_d = cnt_frac_q;
    cnt_d      = cnt_q;
    mod_d      = mod_q;
    ctrl_d     = ctrl_q;
    result_o   = '0;
    case (item_i.func)
      FUNC_TICK: begin
        div_frac_d = div_rem[DIV_FRAC_W-1:0];
        if (div_carry) begin
          div_d = div_q + 8'd1;
        end
        if (ctrl_q[CTRL_EN_BIT]) begin
          if (cnt_carry) begin
            cnt_d = cnt_wrap ? mod_q : cnt_inc;
          end
          // backlog saturates instead of wrapping
          cnt_frac_d = cnt_rem[CNT_FRAC_W] ? CNT_FRAC_MAX : cnt_rem[CNT_FRAC_W-1:0];
          result_o.irq = cnt_wrap;
        end
      end
      FUNC_READ: begin
        result_o.read_data = rd_data;
      end
      FUNC_WRITE: begin
        unique case (item_i.addr)
          ADDR_DIV:  div_d  = 8'd0;
          ADDR_CNT:  cnt_d  = item_i.write_data;
          ADDR_MOD:  mod_d  = item_i.write_data;
          ADDR_CTRL: ctrl_d = item_i.write_data;
          default:   ;
        endcase
      end
      default: ;
    endcase
  end

  // state registers, updated once per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_frac_q <= '0;
      div_q      <= '0;
      cnt_frac_q <= '0;
      cnt_q      <= '0;
      mod_q      <= '0;
      ctrl_q     <= CTRL_RESET;
    end else if (step_i) begin
      div_frac_q <= div_frac_d;
      div_q      <= div_d;
      cnt_frac_q <= cnt_frac_d;
      cnt_q      <= cnt_d;
      mod_q      <= mod_d;
      ctrl_q     <= ctrl_d;
    end
  end

endmodule

// ----- hw/rtl/prescaled_timer_with_reload.sv -----
// ---------------------------------------------------------------------------
// prescaled_timer_with_reload
// divider / counter / modulo / control timer driven by tick and bus beats,
// one result beat per input beat
// ---------------------------------------------------------------------------
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------
//   in       | input     | in_valid_i/in_stall_o | in_item_i  (in_item_t)
//   out      | output    | out_valid_o/out_stall_i | out_item_o (out_item_t)
//
// one beat per cycle sustained while the output is not stalled; a taken beat
// passes through the input register, then the result register, where its
// result becomes valid
// the timer state is updated as a beat moves from the input register into
// the result register, so each beat sees the state left by the one before
// reset clears both stages and loads the control register with 0xf8
// a held result stalls the input only once the input register is also full
// ---------------------------------------------------------------------------
module prescaled_timer_with_reload (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ptwr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ptwr_pkg::out_item_t out_item_o
);
  import ptwr_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      advance;

  // beat moves on when the result register is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // state and update logic
  ptwr_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .result_o (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/ptwr_checker.sv -----
// ---------------------------------------------------------------------------
// ptwr_checker
// port-level checks on the prescaled timer, bound to the top level
// ---------------------------------------------------------------------------
`include "prescaled_timer_with_reload_macros.svh"

module ptwr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input ptwr_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input ptwr_pkg::out_item_t out_item_o
);
  import ptwr_pkg::*;

  logic in_beat;
  logic in_func_ok;

  assign in_beat    = in_valid_i && !in_stall_o;
  assign in_func_ok = (in_item_i.func == FUNC_TICK) || (in_item_i.func == FUNC_READ)
                   || (in_item_i.func == FUNC_WRITE) || !in_valid_i;

  // a held result keeps its value
  `PTWR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o), "result changed while stalled")

  // the input only stalls behind a stalled full result register
  `PTWR_ASSERT_SAME(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without output back-pressure")

  // a beat carries either read data or an interrupt, never both
  `PTWR_ASSERT_SAME(a_irq_no_data, out_valid_o && out_item_o.irq, out_item_o.read_data == 8'd0, "irq with nonzero read data")

  // a taken beat reaches the output through the input and result registers if not stalled
  `PTWR_ASSERT_NEXT(a_latency, in_beat && in_func_ok ##1 !out_stall_i, out_valid_o, "result missing after taken beat")

endmodule

bind prescaled_timer_with_reload ptwr_checker u_ptwr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
